// File: design/like_wildcard_matcher_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the LIKE wildcard matcher
// Shared property wrappers; each use stands on a line of its own.
// ----------------------------------------------------------------------------
`ifndef LIKE_WILDCARD_MATCHER_TOP_MACROS_SVH
`define LIKE_WILDCARD_MATCHER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LWM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lwm: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lwm: next-cycle check failed");

`endif

// File: design/lwm_pkg.sv
// ----------------------------------------------------------------------------
// LIKE wildcard matcher package
// Commands, cell link types, wildcard codes and case folding.
// ----------------------------------------------------------------------------
package lwm_pkg;

    localparam int MAX_PATTERN_DEF = 64;

    localparam logic [7:0] PCT_CHAR = 8'h25;
    localparam logic [7:0] ANY_CHAR = 8'h5F;
    localparam logic [7:0] UPPER_A  = 8'h41;
    localparam logic [7:0] UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_SUBJECT = 2'd2,
        CMD_END     = 2'd3
    } cmd_t;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic       update;
        logic       consume;
        logic       load;
        logic       clear;
        logic [7:0] ch;
    } ctrl_t;

    // Handed from one cell to its right neighbor.
    typedef struct packed {
        logic step;
        logic carry;
        logic valid;
    } link_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= UPPER_A && c <= UPPER_Z)
        begin
            r = c + CASE_OFS;
        end
        return r;
    endfunction

endpackage

// File: design/lwm_item_if.sv
// ----------------------------------------------------------------------------
// LIKE wildcard matcher item channel
// Command beats: pattern loading, subject bytes and end of subject.
// ----------------------------------------------------------------------------
interface lwm_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] character;

    modport source (output valid, output command, output character, input ready);
    modport sink (input valid, input command, input character, output ready);
endinterface

// File: design/lwm_result_if.sv
// ----------------------------------------------------------------------------
// LIKE wildcard matcher result channel
// One beat per end-of-subject command.
// ----------------------------------------------------------------------------
interface lwm_result_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_error;

    modport source (output valid, output matched, output pattern_error, input ready);
    modport sink (input valid, input matched, input pattern_error, output ready);
endinterface

// File: design/lwm_cell.sv
// ----------------------------------------------------------------------------
// LIKE wildcard matcher cell
// Holds one pattern byte and the active bit of its position.
// ----------------------------------------------------------------------------
module lwm_cell
    import lwm_pkg::*;
#(
    parameter bit HEAD = 1'b0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  ctrl_t ctrl,
    input  link_t left,
    output link_t right,
    output logic  hit
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       valid_reg;
    logic       valid_next;
    logic       active_reg;
    logic       active_next;

    logic load;
    logic is_pct;
    logic is_pct_next;
    logic match;
    logic pre;
    logic closed;

    assign load   = ctrl.load && !valid_reg && left.valid;
    assign is_pct = valid_reg && (byte_reg == PCT_CHAR);

    assign valid_next  = ctrl.clear ? 1'b0 : (valid_reg || load);
    assign byte_next   = load ? ctrl.ch : byte_reg;
    assign is_pct_next = valid_next && (byte_next == PCT_CHAR);

    assign match = active_reg && valid_reg && !is_pct &&
                   ((byte_reg == ANY_CHAR) || (byte_reg == ctrl.ch));

    // Pre-closure bit: arrival from the left, or a live '%' holding here.
    assign pre    = left.step || (ctrl.consume && active_reg && is_pct);
    assign closed = pre || left.carry;

    assign active_next = ctrl.update ? closed : active_reg;

    assign right.step  = ctrl.consume && match;
    assign right.carry = is_pct_next && closed;
    assign right.valid = valid_reg;

    // This position is the pattern end when it is the first empty cell.
    assign hit = active_reg && !valid_reg && left.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            active_reg <= HEAD;
        end
        else
        begin
            valid_reg  <= valid_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

// File: design/like_wildcard_matcher_top.sv
// ----------------------------------------------------------------------------
// LIKE wildcard matcher top level
// SQL LIKE matching with '%' and '_', case-insensitive for ASCII letters.
// ----------------------------------------------------------------------------
// Usage:
//   item (sink): command + character beats. CLEAR empties the pattern,
//   APPEND adds one pattern byte, SUBJECT feeds one subject byte, END closes
//   the subject and yields one result beat. Only END produces a result.
//   result (source): matched and pattern_error. pattern_error is set when
//   more bytes were appended than the store holds; matched is then 0.
// Throughput: one item beat per cycle while item.ready is high. Every cell
//   updates its position in parallel for each subject byte; '%' closure
//   ripples along the row of cells within the same cycle, like a carry chain.
// Result: the result beat for END appears in the cycle after acceptance,
//   from a single output register.
// Reset: pattern empty, no overflow, position zero active, no result held.
// Stall: while a result waits, item beats are still taken if the output
//   register drains in the same cycle; otherwise item.ready drops.
// ----------------------------------------------------------------------------
module like_wildcard_matcher_top
    import lwm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    lwm_item_if.sink     item,
    lwm_result_if.source result
);

    `include "like_wildcard_matcher_top_macros.svh"

    ctrl_t ctrl;
    link_t link [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] hits;

    logic accept;
    cmd_t cmd;
    logic end_active_reg;
    logic end_active_next;
    logic ovf_reg;
    logic ovf_next;
    logic full;
    logic hit;
    logic res_valid_reg;
    logic res_valid_next;
    logic matched_reg;
    logic matched_next;
    logic perr_reg;
    logic perr_next;
    logic is_end;
    logic is_clear;
    logic is_append;

    assign item.ready = !res_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;
    assign cmd        = cmd_t'(item.command);

    always_comb
    begin
        is_end    = 1'b0;
        is_clear  = 1'b0;
        is_append = 1'b0;
        case (cmd)
            CMD_CLEAR:   is_clear  = 1'b1;
            CMD_APPEND:  is_append = 1'b1;
            CMD_SUBJECT: is_end    = 1'b0;
            CMD_END:     is_end    = 1'b1;
            default:     is_end    = 1'b0;
        endcase
    end

    assign ctrl.update  = accept;
    assign ctrl.consume = accept && (cmd == CMD_SUBJECT);
    assign ctrl.load    = accept && is_append;
    assign ctrl.clear   = accept && is_clear;
    assign ctrl.ch      = fold_case(item.character);

    // Head of the row: restart seeds position zero.
    assign link[0].step  = accept && (cmd != CMD_SUBJECT);
    assign link[0].carry = 1'b0;
    assign link[0].valid = 1'b1;

    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        lwm_cell #(
            .HEAD (i == 0)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .left  (link[i]),
            .right (link[i+1]),
            .hit   (hits[i])
        );
    end

    assign full = link[MAX_PATTERN].valid;
    assign hit  = (|hits) || (end_active_reg && full);

    assign end_active_next = accept ? (link[MAX_PATTERN].step || link[MAX_PATTERN].carry)
                                    : end_active_reg;
    assign ovf_next = ctrl.clear ? 1'b0 : ((ctrl.load && full) ? 1'b1 : ovf_reg);

    assign res_valid_next = (accept && is_end) || (res_valid_reg && !result.ready);
    assign matched_next   = (accept && is_end) ? (hit && !ovf_reg) : matched_reg;
    assign perr_next      = (accept && is_end) ? ovf_reg : perr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_active_reg <= 1'b0;
            ovf_reg        <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            end_active_reg <= end_active_next;
            ovf_reg        <= ovf_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
        perr_reg    <= perr_next;
    end

    assign result.valid         = res_valid_reg;
    assign result.matched       = matched_reg;
    assign result.pattern_error = perr_reg;

    `LWM_ASSERT_SAME(a_err_no_match, clk, rst_n, res_valid_reg && perr_reg, !matched_reg)
    `LWM_ASSERT_NEXT(a_end_gives_beat, clk, rst_n, accept && is_end, res_valid_reg)
    `LWM_ASSERT_NEXT(a_clear_drops_ovf, clk, rst_n, ctrl.clear, !ovf_reg && !full)
    `LWM_ASSERT_SAME(a_end_bit_needs_full, clk, rst_n, end_active_reg, full)

endmodule
